@@ hdl/assert_macros.svh @@
// Assertion macros used by the SPI allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tsa_pkg.sv @@
// Package of the tunnel SPI allocator: sizes, codes, state and bus types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package tsa_pkg;

  // Table geometry and reference count width.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned REF_BITS      = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ADDR_W        = 128;
  localparam int unsigned SPI_W         = 32;

  localparam logic [SPI_W-1:0]    SPI_LOWEST  = 32'h0000_0001;
  localparam logic [SPI_W-1:0]    SPI_HIGHEST = 32'hffff_ffff;
  localparam logic [REF_BITS-1:0] REFS_MAX    = {REF_BITS{1'b1}};

  // Request codes; the unused code behaves as a lookup.
  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_NEW       = 3'd2,
    ST_REF_ADDED = 3'd3,
    ST_FULL      = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_REMOVED   = 3'd6,
    ST_FREE_MISS = 3'd7
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_PROBE,
    S_PROBE_END
  } state_t;

  // Access to the entry table: one read and one write port.
  typedef struct packed {
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SPI_W-1:0]    wr_spi;
    logic [REF_BITS-1:0] wr_refs;
    logic                wr_valid;
  } tbl_req_t;

  // Registered read data of the entry table.
  typedef struct packed {
    logic                rvalid;
    logic [IDX_W-1:0]    ridx;
    logic                valid;
    logic [ADDR_W-1:0]   addr;
    logic [SPI_W-1:0]    spi;
    logic [REF_BITS-1:0] refs;
  } tbl_rsp_t;

  // Outcome of the shared compare unit.
  typedef struct packed {
    logic addr_hit;
    logic spi_hit;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ hdl/tsa_table.sv @@
// Entry table of the SPI allocator: address, SPI and count memory plus valid bits.
// Depends on tsa_pkg.
`default_nettype none

module tsa_table (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsa_pkg::tbl_req_t req,
  output tsa_pkg::tbl_rsp_t      rsp
);

  logic [tsa_pkg::ADDR_W-1:0]   mem_addr [tsa_pkg::TABLE_ENTRIES];
  logic [tsa_pkg::SPI_W-1:0]    mem_spi  [tsa_pkg::TABLE_ENTRIES];
  logic [tsa_pkg::REF_BITS-1:0] mem_refs [tsa_pkg::TABLE_ENTRIES];
  logic [tsa_pkg::TABLE_ENTRIES-1:0] valid_r;

  logic                         rvalid_r;
  logic [tsa_pkg::IDX_W-1:0]    ridx_r;
  logic                         rd_valid_r;
  logic [tsa_pkg::ADDR_W-1:0]   rd_addr_r;
  logic [tsa_pkg::SPI_W-1:0]    rd_spi_r;
  logic [tsa_pkg::REF_BITS-1:0] rd_refs_r;

  // Memory write port; entries are only meaningful while their valid bit is set.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_addr[req.wr_idx] <= req.wr_addr;
      mem_spi[req.wr_idx]  <= req.wr_spi;
      mem_refs[req.wr_idx] <= req.wr_refs;
    end
  end

  // Valid bits are cleared together at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_idx] <= req.wr_valid;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    ridx_r     <= req.rd_idx;
    rd_valid_r <= valid_r[req.rd_idx];
    rd_addr_r  <= mem_addr[req.rd_idx];
    rd_spi_r   <= mem_spi[req.rd_idx];
    rd_refs_r  <= mem_refs[req.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= req.rd_en;
    end
  end

  assign rsp.rvalid = rvalid_r;
  assign rsp.ridx   = ridx_r;
  assign rsp.valid  = rd_valid_r;
  assign rsp.addr   = rd_addr_r;
  assign rsp.spi    = rd_spi_r;
  assign rsp.refs   = rd_refs_r;

endmodule

`default_nettype wire

@@ hdl/tsa_cmp.sv @@
// Shared compare unit: matches one table entry against the request address
// and the SPI candidate. Depends on tsa_pkg.
`default_nettype none

module tsa_cmp (
  input  wire logic [tsa_pkg::ADDR_W-1:0] key_addr,
  input  wire logic [tsa_pkg::SPI_W-1:0]  cand_spi,
  input  wire tsa_pkg::tbl_rsp_t          rsp,
  output tsa_pkg::cmp_res_t               res
);

  logic live;

  // Only a read that returned a valid entry can match.
  assign live = rsp.rvalid && rsp.valid;

  assign res.addr_hit = live && (rsp.addr == key_addr);
  assign res.spi_hit  = live && (rsp.spi == cand_spi);

endmodule

`default_nettype wire

@@ hdl/tunnel_spi_allocator.sv @@
// Top level of the tunnel SPI allocator: request sequencer, SPI rotor and result register.
// Depends on tsa_pkg, tsa_table, tsa_cmp and assert_macros.svh.
//
// Usage: drive in_req_type and the four address words and raise start; the request
// is taken at a clock edge where start is high and busy is low. busy stays high
// until the request is finished. Each request gives exactly one result, shown on
// out_spi_value, out_status and out_ref_count for one cycle with out_valid high;
// the receiver cannot hold it off and must take it in that cycle.
// Sequence, with N table entries (64): every request first scans the whole table
// through the single registered read port, then decides in S_DECIDE, where a
// lookup, release, reference or full-table allocation ends; its result appears
// as busy falls. An allocation on a new address then probes SPI candidates from
// the rotor onwards, each probe a further full table pass, one to N probes.
// A new request may be taken in the cycle that shows the previous result.
// Reset (synchronous, rst_n low) empties the table and clears the rotor at once.
`default_nettype none

module tunnel_spi_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_addr_w0,
  input  wire logic [31:0] in_addr_w1,
  input  wire logic [31:0] in_addr_w2,
  input  wire logic [31:0] in_addr_w3,
  output logic             out_valid,
  output logic [31:0]      out_spi_value,
  output logic [2:0]       out_status,
  output logic [15:0]      out_ref_count
);

  `include "assert_macros.svh"

  localparam logic [tsa_pkg::CNT_W-1:0] SCAN_END = tsa_pkg::CNT_W'(tsa_pkg::TABLE_ENTRIES);
  localparam logic [tsa_pkg::IDX_W-1:0] LAST_IDX =
    tsa_pkg::IDX_W'(tsa_pkg::TABLE_ENTRIES - 1);

  tsa_pkg::state_t state_r, state_nxt;

  logic [1:0]                   req_r, req_nxt;
  logic [tsa_pkg::ADDR_W-1:0]   key_r, key_nxt;
  logic [tsa_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic                         hit_found_r, hit_found_nxt;
  logic [tsa_pkg::IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [tsa_pkg::SPI_W-1:0]    hit_spi_r, hit_spi_nxt;
  logic [tsa_pkg::REF_BITS-1:0] hit_refs_r, hit_refs_nxt;
  logic                         free_found_r, free_found_nxt;
  logic [tsa_pkg::IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [tsa_pkg::SPI_W-1:0]    cand_r, cand_nxt;
  logic                         in_use_r, in_use_nxt;
  logic [tsa_pkg::SPI_W-1:0]    rotor_r, rotor_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [tsa_pkg::SPI_W-1:0]    out_spi_r, out_spi_nxt;
  tsa_pkg::status_t             out_status_r, out_status_nxt;
  logic [tsa_pkg::REF_BITS-1:0] out_refs_r, out_refs_nxt;

  tsa_pkg::tbl_req_t tbl_req;
  tsa_pkg::tbl_rsp_t tbl_rsp;
  tsa_pkg::cmp_res_t cmp_res;

  logic                         last_rd;
  logic [tsa_pkg::SPI_W-1:0]    start_cand;
  logic [tsa_pkg::SPI_W-1:0]    next_cand;
  logic [tsa_pkg::REF_BITS-1:0] refs_inc;

  tsa_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  tsa_cmp u_cmp (
    .key_addr (key_r),
    .cand_spi (cand_r),
    .rsp      (tbl_rsp),
    .res      (cmp_res)
  );

  // Helper values for the decision and probe steps.
  assign last_rd    = tbl_rsp.rvalid && (tbl_rsp.ridx == LAST_IDX);
  assign start_cand = ((rotor_r < tsa_pkg::SPI_LOWEST) || (rotor_r == tsa_pkg::SPI_HIGHEST))
                      ? tsa_pkg::SPI_LOWEST : rotor_r + tsa_pkg::SPI_W'(1);
  assign next_cand  = (cand_r == tsa_pkg::SPI_HIGHEST)
                      ? tsa_pkg::SPI_LOWEST : cand_r + tsa_pkg::SPI_W'(1);
  assign refs_inc   = (hit_refs_r == tsa_pkg::REFS_MAX)
                      ? hit_refs_r : hit_refs_r + tsa_pkg::REF_BITS'(1);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsa_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = tsa_pkg::S_SCAN;
        end
      end
      tsa_pkg::S_SCAN: begin
        if (last_rd) begin
          state_nxt = tsa_pkg::S_DECIDE;
        end
      end
      tsa_pkg::S_DECIDE: begin
        if ((req_r == tsa_pkg::REQ_ALLOC) && !hit_found_r && free_found_r) begin
          state_nxt = tsa_pkg::S_PROBE;
        end else begin
          state_nxt = tsa_pkg::S_IDLE;
        end
      end
      tsa_pkg::S_PROBE: begin
        if (last_rd) begin
          state_nxt = tsa_pkg::S_PROBE_END;
        end
      end
      tsa_pkg::S_PROBE_END: begin
        if (in_use_r) begin
          state_nxt = tsa_pkg::S_PROBE;
        end else begin
          state_nxt = tsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsa_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, table accesses and result for each state.
  always_comb begin
    req_nxt        = req_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_spi_nxt    = hit_spi_r;
    hit_refs_nxt   = hit_refs_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    cand_nxt       = cand_r;
    in_use_nxt     = in_use_r;
    rotor_nxt      = rotor_r;
    out_valid_nxt  = 1'b0;
    out_spi_nxt    = out_spi_r;
    out_status_nxt = out_status_r;
    out_refs_nxt   = out_refs_r;

    tbl_req          = '0;
    tbl_req.rd_idx   = idx_r[tsa_pkg::IDX_W-1:0];
    tbl_req.wr_addr  = key_r;

    case (state_r)
      tsa_pkg::S_IDLE: begin
        if (start) begin
          req_nxt        = in_req_type;
          key_nxt        = {in_addr_w0, in_addr_w1, in_addr_w2, in_addr_w3};
          idx_nxt        = '0;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
        end
      end

      tsa_pkg::S_SCAN: begin
        if (idx_r < SCAN_END) begin
          tbl_req.rd_en = 1'b1;
          idx_nxt       = idx_r + tsa_pkg::CNT_W'(1);
        end
        // Keep the first matching entry and the first empty slot.
        if (cmp_res.addr_hit && !hit_found_r) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = tbl_rsp.ridx;
          hit_spi_nxt   = tbl_rsp.spi;
          hit_refs_nxt  = tbl_rsp.refs;
        end
        if (tbl_rsp.rvalid && !tbl_rsp.valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = tbl_rsp.ridx;
        end
      end

      tsa_pkg::S_DECIDE: begin
        case (req_r)
          tsa_pkg::REQ_ALLOC: begin
            if (hit_found_r) begin
              tbl_req.wr_en    = 1'b1;
              tbl_req.wr_idx   = hit_idx_r;
              tbl_req.wr_spi   = hit_spi_r;
              tbl_req.wr_refs  = refs_inc;
              tbl_req.wr_valid = 1'b1;
              out_valid_nxt    = 1'b1;
              out_spi_nxt      = hit_spi_r;
              out_status_nxt   = tsa_pkg::ST_REF_ADDED;
              out_refs_nxt     = refs_inc;
            end else if (!free_found_r) begin
              out_valid_nxt  = 1'b1;
              out_spi_nxt    = '0;
              out_status_nxt = tsa_pkg::ST_FULL;
              out_refs_nxt   = '0;
            end else begin
              cand_nxt   = start_cand;
              idx_nxt    = '0;
              in_use_nxt = 1'b0;
            end
          end
          tsa_pkg::REQ_RELEASE: begin
            out_valid_nxt = 1'b1;
            if (!hit_found_r) begin
              out_spi_nxt    = '0;
              out_status_nxt = tsa_pkg::ST_FREE_MISS;
              out_refs_nxt   = '0;
            end else if (hit_refs_r <= tsa_pkg::REF_BITS'(1)) begin
              // Last reference gone: drop the entry.
              tbl_req.wr_en    = 1'b1;
              tbl_req.wr_idx   = hit_idx_r;
              tbl_req.wr_spi   = hit_spi_r;
              tbl_req.wr_refs  = '0;
              tbl_req.wr_valid = 1'b0;
              out_spi_nxt      = hit_spi_r;
              out_status_nxt   = tsa_pkg::ST_REMOVED;
              out_refs_nxt     = '0;
            end else begin
              tbl_req.wr_en    = 1'b1;
              tbl_req.wr_idx   = hit_idx_r;
              tbl_req.wr_spi   = hit_spi_r;
              tbl_req.wr_refs  = hit_refs_r - tsa_pkg::REF_BITS'(1);
              tbl_req.wr_valid = 1'b1;
              out_spi_nxt      = hit_spi_r;
              out_status_nxt   = tsa_pkg::ST_RELEASED;
              out_refs_nxt     = hit_refs_r - tsa_pkg::REF_BITS'(1);
            end
          end
          default: begin
            // Lookup, and the unused request code, which acts the same.
            out_valid_nxt = 1'b1;
            if (hit_found_r) begin
              out_spi_nxt    = hit_spi_r;
              out_status_nxt = tsa_pkg::ST_FOUND;
              out_refs_nxt   = hit_refs_r;
            end else begin
              out_spi_nxt    = '0;
              out_status_nxt = tsa_pkg::ST_NOT_FOUND;
              out_refs_nxt   = '0;
            end
          end
        endcase
      end

      tsa_pkg::S_PROBE: begin
        if (idx_r < SCAN_END) begin
          tbl_req.rd_en = 1'b1;
          idx_nxt       = idx_r + tsa_pkg::CNT_W'(1);
        end
        if (cmp_res.spi_hit) begin
          in_use_nxt = 1'b1;
        end
      end

      tsa_pkg::S_PROBE_END: begin
        if (in_use_r) begin
          // Candidate taken: move on, wrapping past the top to the lowest SPI.
          cand_nxt   = next_cand;
          idx_nxt    = '0;
          in_use_nxt = 1'b0;
        end else begin
          tbl_req.wr_en    = 1'b1;
          tbl_req.wr_idx   = free_idx_r;
          tbl_req.wr_spi   = cand_r;
          tbl_req.wr_refs  = tsa_pkg::REF_BITS'(1);
          tbl_req.wr_valid = 1'b1;
          rotor_nxt        = cand_r;
          out_valid_nxt    = 1'b1;
          out_spi_nxt      = cand_r;
          out_status_nxt   = tsa_pkg::ST_NEW;
          out_refs_nxt     = tsa_pkg::REF_BITS'(1);
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsa_pkg::S_IDLE;
      rotor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rotor_r     <= rotor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_spi_r    <= hit_spi_nxt;
    hit_refs_r   <= hit_refs_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    cand_r       <= cand_nxt;
    in_use_r     <= in_use_nxt;
    out_spi_r    <= out_spi_nxt;
    out_status_r <= out_status_nxt;
    out_refs_r   <= out_refs_nxt;
  end

  assign busy          = (state_r != tsa_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_spi_value = out_spi_r;
  assign out_status    = out_status_r;
  assign out_ref_count = 16'(out_refs_r);

  // A result only ends a request that was in progress.
  `ASSERT_IMPLIES(a_result_after_busy, clk, rst_n, out_valid, $past(busy), "result without request")
  // One result per request: strobes never come back to back.
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "repeated result strobe")
  // An accepted request makes the block busy.
  `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "request not taken")
  // A newly assigned SPI is never zero.
  `ASSERT_IMPLIES(a_new_spi_nonzero, clk, rst_n, out_valid && (out_status == tsa_pkg::ST_NEW),
    out_spi_value != '0, "zero SPI assigned")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for tunnel_spi_allocator: directed and random requests, each
// reply checked against a behavioural copy of the SPI table kept inside the bench.
// Depends on tsa_pkg and the tunnel_spi_allocator RTL.

module tb;

  // The spare request code behaves as a lookup.
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int POOL_SIZE = 80;
  // One full table pass plus a probe pass bounds the work left after the last reply.
  localparam int SETTLE_CYCLES = 2 * (tsa_pkg::TABLE_ENTRIES + 2);

  typedef struct packed {
    logic [31:0]      spi;
    tsa_pkg::status_t status;
    logic [15:0]      refs;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = tsa_pkg::REQ_LOOKUP;
  logic [31:0] in_addr_w0 = '0;
  logic [31:0] in_addr_w1 = '0;
  logic [31:0] in_addr_w2 = '0;
  logic [31:0] in_addr_w3 = '0;
  logic        out_valid;
  logic [31:0] out_spi_value;
  logic [2:0]  out_status;
  logic [15:0] out_ref_count;

  // Behavioural copy of the SPI table.
  bit                         tbl_valid [tsa_pkg::TABLE_ENTRIES];
  bit [127:0]                 tbl_addr  [tsa_pkg::TABLE_ENTRIES];
  bit [31:0]                  tbl_spi   [tsa_pkg::TABLE_ENTRIES];
  bit [tsa_pkg::REF_BITS-1:0] tbl_refs  [tsa_pkg::TABLE_ENTRIES];
  bit [31:0]                  spi_rotor = '0;
  int                         live_entries = 0;

  reply_t     replies_due[$];
  reply_t     oldest_reply;
  logic [127:0] addr_pool [POOL_SIZE];
  int         mismatch_count = 0;
  bit         back_to_back = 1'b0;

  tunnel_spi_allocator u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_addr_w0    (in_addr_w0),
    .in_addr_w1    (in_addr_w1),
    .in_addr_w2    (in_addr_w2),
    .in_addr_w3    (in_addr_w3),
    .out_valid     (out_valid),
    .out_spi_value (out_spi_value),
    .out_status    (out_status),
    .out_ref_count (out_ref_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the table copy and returns the reply it should give.
  function automatic reply_t predict_reply(input logic [1:0] kind, input logic [127:0] addr);
    reply_t      r;
    int          hit;
    int          slot;
    bit          taken;
    logic [31:0] cand;
    hit  = -1;
    slot = -1;
    // Walk downwards so that the lowest matching and lowest free slots win.
    for (int i = tsa_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_addr[i] == addr) hit = i;
      if (!tbl_valid[i]) slot = i;
    end
    r = '{32'd0, tsa_pkg::ST_NOT_FOUND, 16'd0};
    case (kind)
      tsa_pkg::REQ_ALLOC: begin
        if (hit >= 0) begin
          if (tbl_refs[hit] < tsa_pkg::REFS_MAX) tbl_refs[hit]++;
          r = '{tbl_spi[hit], tsa_pkg::ST_REF_ADDED, 16'(tbl_refs[hit])};
        end else if (slot < 0) begin
          r = '{32'd0, tsa_pkg::ST_FULL, 16'd0};
        end else begin
          // Advance the rotor, then step past any SPI that a live entry holds.
          cand = (spi_rotor < tsa_pkg::SPI_LOWEST || spi_rotor >= tsa_pkg::SPI_HIGHEST) ?
                 tsa_pkg::SPI_LOWEST : spi_rotor + 32'd1;
          taken = 1'b1;
          for (int n = 0; n <= tsa_pkg::TABLE_ENTRIES && taken; n++) begin
            taken = 1'b0;
            foreach (tbl_valid[j]) begin
              if (tbl_valid[j] && tbl_spi[j] == cand) taken = 1'b1;
            end
            if (taken) begin
              cand = (cand >= tsa_pkg::SPI_HIGHEST) ? tsa_pkg::SPI_LOWEST : cand + 32'd1;
            end
          end
          spi_rotor       = cand;
          tbl_valid[slot] = 1'b1;
          tbl_addr[slot]  = addr;
          tbl_spi[slot]   = cand;
          tbl_refs[slot]  = tsa_pkg::REF_BITS'(1);
          live_entries++;
          r = '{cand, tsa_pkg::ST_NEW, 16'd1};
        end
      end
      tsa_pkg::REQ_RELEASE: begin
        if (hit < 0) begin
          r = '{32'd0, tsa_pkg::ST_FREE_MISS, 16'd0};
        end else if (tbl_refs[hit] <= tsa_pkg::REF_BITS'(1)) begin
          tbl_valid[hit] = 1'b0;
          tbl_refs[hit]  = '0;
          live_entries--;
          r = '{tbl_spi[hit], tsa_pkg::ST_REMOVED, 16'd0};
        end else begin
          tbl_refs[hit]--;
          r = '{tbl_spi[hit], tsa_pkg::ST_RELEASED, 16'(tbl_refs[hit])};
        end
      end
      default: begin
        if (hit >= 0) r = '{tbl_spi[hit], tsa_pkg::ST_FOUND, 16'(tbl_refs[hit])};
      end
    endcase
    return r;
  endfunction

  function automatic logic [127:0] random_address();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Sends one request after a random gap (none while back_to_back is set) and records the reply it should give.
  // Start is left high on return so that a following request can go back to back.
  task automatic issue_request(input logic [1:0] kind, input logic [127:0] addr);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= kind;
    in_addr_w0  <= addr[127:96];
    in_addr_w1  <= addr[95:64];
    in_addr_w2  <= addr[63:32];
    in_addr_w3  <= addr[31:0];
    do @(posedge clk); while (busy !== 1'b0);
    replies_due.push_back(predict_reply(kind, addr));
  endtask

  // Holds the sender off until every outstanding reply has arrived.
  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // Each reply is compared field by field with the oldest outstanding one.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply spi %h status %0d refs %0d", $time,
                 out_spi_value, out_status, out_ref_count);
        mismatch_count++;
      end else begin
        oldest_reply = replies_due.pop_front();
        if (out_spi_value !== oldest_reply.spi) begin
          $display("%0t: spi_value expected %h got %h", $time, oldest_reply.spi,
                   out_spi_value);
          mismatch_count++;
        end
        if (out_status !== oldest_reply.status) begin
          $display("%0t: status expected %0d got %0d", $time, oldest_reply.status,
                   out_status);
          mismatch_count++;
        end
        if (out_ref_count !== oldest_reply.refs) begin
          $display("%0t: ref_count expected %0d got %0d", $time, oldest_reply.refs,
                   out_ref_count);
          mismatch_count++;
        end
      end
    end
  end

  // Requests against an empty table, including the spare request code.
  task automatic test_empty_table();
    issue_request(tsa_pkg::REQ_LOOKUP, '0);
    issue_request(tsa_pkg::REQ_RELEASE, '1);
    issue_request(REQ_SPARE, '1);
  endtask

  // One address taken through allocation, reference, lookup, release and removal.
  task automatic test_entry_lifecycle();
    logic [127:0] addr;
    addr = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
    issue_request(tsa_pkg::REQ_ALLOC, addr);
    issue_request(tsa_pkg::REQ_ALLOC, addr);
    issue_request(tsa_pkg::REQ_LOOKUP, addr);
    issue_request(REQ_SPARE, addr);
    issue_request(tsa_pkg::REQ_RELEASE, addr);
    issue_request(tsa_pkg::REQ_RELEASE, addr);
    issue_request(tsa_pkg::REQ_LOOKUP, addr);
    issue_request(tsa_pkg::REQ_RELEASE, addr);
  endtask

  // All-zero and all-ones addresses, and one that differs from zero in the top bit only.
  task automatic test_address_extremes();
    issue_request(tsa_pkg::REQ_ALLOC, '1);
    issue_request(tsa_pkg::REQ_ALLOC, '0);
    issue_request(tsa_pkg::REQ_ALLOC, {1'b1, 127'd0});
    issue_request(tsa_pkg::REQ_LOOKUP, '0);
    issue_request(tsa_pkg::REQ_RELEASE, '1);
  endtask

  // Fills every slot, then checks full replies and that a freed slot is reused.
  task automatic test_table_full();
    int k;
    k = 0;
    while (live_entries < tsa_pkg::TABLE_ENTRIES && k < POOL_SIZE - 4) begin
      issue_request(tsa_pkg::REQ_ALLOC, addr_pool[k]);
      k++;
    end
    repeat (4) issue_request(tsa_pkg::REQ_ALLOC, addr_pool[k + $urandom_range(0, 3)]);
    issue_request(tsa_pkg::REQ_ALLOC, addr_pool[0]);
    issue_request(tsa_pkg::REQ_LOOKUP, addr_pool[k]);
    issue_request(tsa_pkg::REQ_RELEASE, addr_pool[5]);
    issue_request(tsa_pkg::REQ_ALLOC, addr_pool[k]);
    issue_request(tsa_pkg::REQ_ALLOC, addr_pool[k + 1]);
    wait_for_replies();
  endtask

  // Mixed traffic over the address pool, with a little noise on fresh addresses.
  task automatic run_pool_traffic(input int count, input int alloc_pct, input int release_pct);
    int           roll;
    logic [1:0]   kind;
    logic [127:0] addr;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        addr = random_address();
        case ($urandom_range(0, 2))
          0:       kind = tsa_pkg::REQ_LOOKUP;
          1:       kind = tsa_pkg::REQ_RELEASE;
          default: kind = REQ_SPARE;
        endcase
      end else begin
        addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) kind = tsa_pkg::REQ_ALLOC;
        else if (roll < alloc_pct + release_pct) kind = tsa_pkg::REQ_RELEASE;
        else if (roll < 96) kind = tsa_pkg::REQ_LOOKUP;
        else kind = REQ_SPARE;
      end
      issue_request(kind, addr);
    end
  endtask

  // Phases swing the table between full and empty; one runs without sender gaps.
  task automatic test_random_traffic();
    run_pool_traffic(400, 45, 35);
    wait_for_replies();
    back_to_back = 1'b1;
    run_pool_traffic(150, 70, 15);
    back_to_back = 1'b0;
    run_pool_traffic(150, 70, 15);
    wait_for_replies();
    run_pool_traffic(300, 20, 65);
    wait_for_replies();
    run_pool_traffic(300, 45, 40);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_entry_lifecycle();
    test_address_extremes();
    wait_for_replies();
    // Pairs of pool addresses differ in a single bit, so both halves of the compare count.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) addr_pool[i] = addr_pool[i - 1] ^ (128'd1 << $urandom_range(0, 127));
      else addr_pool[i] = random_address();
    end
    test_table_full();
    test_random_traffic();
    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tunnel_spi_allocator regression: pass");
    end else begin
      $display("tunnel_spi_allocator regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("tunnel_spi_allocator regression: fail");
    $finish;
  end

endmodule
